// File: hdl/ifdc_pkg.sv
// ----------------------------------------------------------------------------
// ifdc_pkg
// Shared constants and types of the information frame deframer and checker.
// ----------------------------------------------------------------------------
package ifdc_pkg;

  // Line codes
  localparam logic [7:0] FLAG_BYTE   = 8'd126;
  localparam logic [7:0] ESCAPE_BYTE = 8'd125;
  localparam logic [7:0] CODE_FLAG   = 8'h5E;
  localparam logic [7:0] CODE_ESC    = 8'h5D;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ADDRESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INFO_CONTROL_ZERO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFO_CONTROL_ONE  = 2'd2;

  // Configuration reset values
  localparam logic [7:0] FRAME_ADDRESS_RST     = 8'd3;
  localparam logic [7:0] INFO_CONTROL_ZERO_RST = 8'd0;
  localparam logic [7:0] INFO_CONTROL_ONE_RST  = 8'd64;

  typedef struct packed {
    logic [7:0] frame_address;
    logic [7:0] info_control_zero;
    logic [7:0] info_control_one;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       ack_sequence;
    logic       frame_end;
  } result_t;

endpackage

// File: hdl/ifdc_frame_fsm.sv
// ----------------------------------------------------------------------------
// ifdc_frame_fsm
// Frame hunt, header check, destuffing and trailer check for one byte a step.
// ----------------------------------------------------------------------------
module ifdc_frame_fsm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ifdc_pkg::cfg_t  cfg_i,
  input  logic            step_i,
  input  logic [7:0]      rx_byte_i,
  output ifdc_pkg::result_t res_o,
  output logic            rx_seq_o
);
  import ifdc_pkg::*;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_FLAG = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic       esc_q, esc_d;
  logic [7:0] check_q, check_d;
  logic       seq_q, seq_d;

  always_comb begin
    phase_d    = phase_q;
    ctrl_d     = ctrl_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    esc_d      = esc_q;
    check_d    = check_q;
    seq_d      = seq_q;
    res_o      = '0;
    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == FLAG_BYTE) phase_d = PH_FLAG;
      end
      PH_FLAG: begin
        if (rx_byte_i == cfg_i.frame_address) phase_d = PH_ADDR;
        else if (rx_byte_i != FLAG_BYTE) phase_d = PH_HUNT;
      end
      PH_ADDR: begin
        if (rx_byte_i == cfg_i.info_control_zero ||
            rx_byte_i == cfg_i.info_control_one) begin
          ctrl_d  = rx_byte_i;
          phase_d = PH_CTRL;
        end else if (rx_byte_i == FLAG_BYTE) begin
          phase_d = PH_FLAG;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_CTRL: begin
        // header check is tested before the flag
        if (rx_byte_i == (cfg_i.frame_address ^ ctrl_q)) begin
          held_d     = '0;
          held_vld_d = 1'b0;
          esc_d      = 1'b0;
          check_d    = '0;
          phase_d    = PH_DATA;
        end else if (rx_byte_i == FLAG_BYTE) begin
          phase_d = PH_FLAG;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (esc_q && rx_byte_i == CODE_FLAG) begin
          held_d = FLAG_BYTE;
          esc_d  = (FLAG_BYTE == ESCAPE_BYTE);
        end else if (esc_q && rx_byte_i == CODE_ESC) begin
          held_d = ESCAPE_BYTE;
          esc_d  = 1'b0;
        end else if (rx_byte_i == FLAG_BYTE) begin
          held_d     = '0;
          held_vld_d = 1'b0;
          esc_d      = 1'b0;
          check_d    = '0;
          if (!held_vld_q) begin
            // empty frame: flag opens a new one
            phase_d = PH_FLAG;
          end else begin
            phase_d         = PH_HUNT;
            res_o.valid     = 1'b1;
            res_o.frame_end = 1'b1;
            if (held_q == check_q) begin
              res_o.result_kind  = KIND_ACCEPT;
              res_o.ack_sequence = seq_q;
              seq_d              = ~seq_q;
            end else begin
              res_o.result_kind  = KIND_REJECT;
              res_o.ack_sequence = ~seq_q;
            end
          end
        end else begin
          if (held_vld_q) begin
            res_o.valid        = 1'b1;
            res_o.result_kind  = KIND_PAYLOAD;
            res_o.payload_byte = held_q;
            check_d            = check_q ^ held_q;
          end
          held_d     = rx_byte_i;
          held_vld_d = 1'b1;
          esc_d      = (rx_byte_i == ESCAPE_BYTE);
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      ctrl_q     <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      esc_q      <= 1'b0;
      check_q    <= '0;
      seq_q      <= 1'b1;
    end else if (step_i) begin
      phase_q    <= phase_d;
      ctrl_q     <= ctrl_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      esc_q      <= esc_d;
      check_q    <= check_d;
      seq_q      <= seq_d;
    end
  end

  assign rx_seq_o = seq_q;

endmodule

// File: hdl/ifdc_out_buf.sv
// ----------------------------------------------------------------------------
// ifdc_out_buf
// Two-entry result buffer between the frame logic and the output stream.
// ----------------------------------------------------------------------------
module ifdc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ifdc_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  output ifdc_pkg::result_t data_o,
  input  logic              pop_ready_i
);
  import ifdc_pkg::*;

  result_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign push    = push_i && ready_o;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// File: hdl/info_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// info_frame_deframer_checker
// Byte-stuffed information frame receiver with header and trailer checks.
// ----------------------------------------------------------------------------
// Usage:
//   Raw line bytes enter on the s_axis group, one per transfer. Results leave
//   on the m_axis group: a destuffed payload byte (tuser = payload) or a
//   frame verdict (tuser = accept or reject, tlast high) with the sequence
//   number to acknowledge. Payload bytes come out one byte late, as the last
//   byte of a frame is the trailer check. Discard payload of rejected frames.
//   Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i and
//   should only change while the block is idle.
// Timing:
//   One byte per cycle sustained, unless a byte with a result waits for
//   space in the result buffer. A byte is held in an input register and run
//   through the frame logic, which writes its result into the result buffer
//   that drives the master side. The rate is set by the frame state update.
// Reset and stall:
//   Reset puts the block into flag hunting, receive sequence one, registers
//   to their defaults. A stalled receiver fills the two-entry result buffer;
//   then s_axis_tready_o drops once a held byte has a result, until space frees.
// ----------------------------------------------------------------------------
module info_frame_deframer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ifdc_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [7:0]                    cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,   // [7:0] payload_byte,
                                                          // [8] ack_sequence
  output logic [1:0]                    m_axis_tuser_o,   // [1:0] result_kind
  output logic                          m_axis_tlast_o    // frame_end
);
  import ifdc_pkg::*;

  cfg_t       cfg_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       buf_ready;
  logic       rx_seq;
  result_t    res;
  result_t    out_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_address     <= FRAME_ADDRESS_RST;
      cfg_q.info_control_zero <= INFO_CONTROL_ZERO_RST;
      cfg_q.info_control_one  <= INFO_CONTROL_ONE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FRAME_ADDRESS:     cfg_q.frame_address     <= cfg_wdata_i;
        REG_INFO_CONTROL_ZERO: cfg_q.info_control_zero <= cfg_wdata_i;
        REG_INFO_CONTROL_ONE:  cfg_q.info_control_one  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a byte without a result never waits for buffer space
  assign step            = in_vld_q && (!res.valid || buf_ready);
  assign s_axis_tready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_byte_q <= s_axis_tdata_i;
  end

  ifdc_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .res_o     (res),
    .rx_seq_o  (rx_seq)
  );

  ifdc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && res.valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid_o),
    .data_o      (out_res),
    .pop_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {7'd0, out_res.ack_sequence, out_res.payload_byte};
  assign m_axis_tuser_o = out_res.result_kind;
  assign m_axis_tlast_o = out_res.frame_end;

  // verdicts carry tlast and no payload byte; payload bytes carry no tlast
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o != KIND_PAYLOAD)))
    else $error("tlast does not match result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("verdict carries a payload byte");

  // receive sequence moves exactly on an accepted frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.valid && res.result_kind == KIND_ACCEPT) |=> (rx_seq != $past(rx_seq)))
    else $error("receive sequence did not toggle on accept");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step && res.valid && res.result_kind == KIND_ACCEPT) |=> (rx_seq == $past(rx_seq)))
    else $error("receive sequence toggled without accept");

endmodule

// File: test/tb_info_frame_deframer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_info_frame_deframer_checker
// Self-checking bench for the byte-stuffed information frame receiver.
// ----------------------------------------------------------------------------
// Line bytes go in on the slave stream: a short directed run through the
// hunting states and escape handling, then random frames (good, broken off,
// badly stuffed, wrong trailer) mixed with line noise, under several register
// settings. A scoreboard predicts each payload byte and verdict and checks
// the master stream in order. Both sides stall at random; one phase holds
// the receiver off long enough to back-pressure the input.
// ----------------------------------------------------------------------------
module tb_info_frame_deframer_checker;
  import ifdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [2:0] {
    S_HUNT, S_GOT_FLAG, S_GOT_ADDR, S_GOT_CTRL, S_IN_DATA
  } hunt_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       seq;
    logic       last;
  } deframed_t;

  class frame_scoreboard;
    logic [7:0]  frame_address;
    logic [7:0]  ctrl_zero;
    logic [7:0]  ctrl_one;
    hunt_e       phase;
    logic [7:0]  seen_ctrl;
    logic [7:0]  held;
    logic        held_valid;
    logic        esc_pending;
    logic [7:0]  check;
    logic        rx_seq;
    deframed_t   deframed_q[$];
    int          errors;

    function new();
      frame_address = FRAME_ADDRESS_RST;
      ctrl_zero     = INFO_CONTROL_ZERO_RST;
      ctrl_one      = INFO_CONTROL_ONE_RST;
      phase         = S_HUNT;
      seen_ctrl     = '0;
      rx_seq        = 1'b1;
      errors        = 0;
      clear_frame();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_FRAME_ADDRESS:     frame_address = val;
        REG_INFO_CONTROL_ZERO: ctrl_zero     = val;
        REG_INFO_CONTROL_ONE:  ctrl_one      = val;
        default: ;
      endcase
    endfunction

    function void clear_frame();
      held        = '0;
      held_valid  = 1'b0;
      esc_pending = 1'b0;
      check       = '0;
    endfunction

    // one accepted line byte; queues the payload byte or verdict it releases
    function void deframe_byte(logic [7:0] b);
      deframed_t r;
      r = '0;
      case (phase)
        S_HUNT:
          if (b == FLAG_BYTE) phase = S_GOT_FLAG;
        S_GOT_FLAG:
          if (b == frame_address) phase = S_GOT_ADDR;
          else if (b != FLAG_BYTE) phase = S_HUNT;
        S_GOT_ADDR:
          if (b == ctrl_zero || b == ctrl_one) begin
            seen_ctrl = b;
            phase     = S_GOT_CTRL;
          end else if (b == FLAG_BYTE) begin
            phase = S_GOT_FLAG;
          end else begin
            phase = S_HUNT;
          end
        S_GOT_CTRL:
          // header check wins over the flag test
          if (b == (frame_address ^ seen_ctrl)) begin
            clear_frame();
            phase = S_IN_DATA;
          end else if (b == FLAG_BYTE) begin
            phase = S_GOT_FLAG;
          end else begin
            phase = S_HUNT;
          end
        S_IN_DATA:
          if (esc_pending && b == CODE_FLAG) begin
            held        = FLAG_BYTE;
            esc_pending = (held == ESCAPE_BYTE);
          end else if (esc_pending && b == CODE_ESC) begin
            held        = ESCAPE_BYTE;
            esc_pending = 1'b0;
          end else if (b == FLAG_BYTE) begin
            if (!held_valid) begin
              // nothing held: treat as a fresh opening flag
              clear_frame();
              phase = S_GOT_FLAG;
            end else begin
              r.last = 1'b1;
              if (held == check) begin
                r.kind = KIND_ACCEPT;
                r.seq  = rx_seq;
                rx_seq = ~rx_seq;
              end else begin
                r.kind = KIND_REJECT;
                r.seq  = ~rx_seq;
              end
              deframed_q.push_back(r);
              clear_frame();
              phase = S_HUNT;
            end
          end else begin
            if (held_valid) begin
              r.kind = KIND_PAYLOAD;
              r.data = held;
              deframed_q.push_back(r);
              check = check ^ held;
            end
            held        = b;
            held_valid  = 1'b1;
            esc_pending = (b == ESCAPE_BYTE);
          end
        default: phase = S_HUNT;
      endcase
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_deframed(logic [1:0] kind, logic [7:0] data, logic seq,
                                 logic last);
      deframed_t e;
      if (deframed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0h byte %0h",
                 $time, kind, data);
        return;
      end
      e = deframed_q.pop_front();
      if (kind !== e.kind) report("result_kind", 8'(e.kind), 8'(kind));
      if (data !== e.data) report("payload_byte", e.data, data);
      if (seq !== e.seq)   report("ack_sequence", 8'(e.seq), 8'(seq));
      if (last !== e.last) report("frame_end", 8'(e.last), 8'(last));
    endfunction

    function int pending();
      return deframed_q.size();
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i      = '0;
  logic [7:0]           cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [15:0]          m_axis_tdata_o;
  logic [1:0]           m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  frame_scoreboard sb = new();
  bit src_busy  = 1'b1;
  bit snk_busy  = 1'b1;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  info_frame_deframer_checker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit busy);
    int unsigned r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_stuffed(ref logic [7:0] q[$], input logic [7:0] b);
    if (b == FLAG_BYTE) begin
      q.push_back(ESCAPE_BYTE);
      q.push_back(CODE_FLAG);
    end else if (b == ESCAPE_BYTE) begin
      q.push_back(ESCAPE_BYTE);
      q.push_back(CODE_ESC);
    end else begin
      q.push_back(b);
    end
  endfunction

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return FLAG_BYTE;
      1:       return ESCAPE_BYTE;
      2:       return ($urandom_range(0, 1) != 0) ? CODE_FLAG : CODE_ESC;
      3:       return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void build_frame(ref logic [7:0] q[$],
                                      input logic [7:0] addr, z, o);
    logic [7:0]  ctrl;
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned len;
    int unsigned variant;
    ctrl = ($urandom_range(0, 1) != 0) ? o : z;
    repeat (($urandom_range(0, 3) == 0) ? 2 : 1) q.push_back(FLAG_BYTE);
    q.push_back(addr);
    q.push_back(ctrl);
    q.push_back(addr ^ ctrl);
    variant = $urandom_range(0, 99);
    if (variant < 3) begin
      // closing flag straight after the header
      q.push_back(FLAG_BYTE);
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    sum = '0;
    repeat (len) begin
      b   = pick_payload();
      sum = sum ^ b;
      push_stuffed(q, b);
    end
    if (variant < 6) begin
      // escape followed by a byte that is no escape code
      q.push_back(ESCAPE_BYTE);
      q.push_back(8'($urandom_range(0, 8'h5C)));
    end else if (variant < 9) begin
      // frame closed while an escape is pending
      q.push_back(ESCAPE_BYTE);
      q.push_back(FLAG_BYTE);
      return;
    end
    if (variant < 80) push_stuffed(q, sum);
    else push_stuffed(q, sum ^ 8'($urandom_range(1, 255)));
    q.push_back(FLAG_BYTE);
  endfunction

  // returns the number of bytes that belong to frame attempts
  function automatic int build_burst(ref logic [7:0] q[$], input logic [7:0] addr, z, o);
    logic [7:0]  t[$];
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      build_frame(q, addr, z, o);
      return q.size();
    end
    if (pick < 88) begin
      // frame broken off at a random point
      build_frame(t, addr, z, o);
      cut = $urandom_range(1, t.size() - 1);
      for (int i = 0; i < cut; i++) q.push_back(t[i]);
      q.push_back(8'($urandom));
      return q.size();
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 4))
        0:       q.push_back(FLAG_BYTE);
        1:       q.push_back(addr);
        2:       q.push_back(z);
        3:       q.push_back(o);
        default: q.push_back(8'($urandom));
      endcase
    end
    return 0;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(src_busy);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.deframe_byte(b);
  endtask

  task automatic configure(input logic [7:0] addr, z, o);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_FRAME_ADDRESS;
    cfg_wdata_i <= addr;
    @(negedge clk_i);
    cfg_addr_i  <= REG_INFO_CONTROL_ZERO;
    cfg_wdata_i <= z;
    @(negedge clk_i);
    cfg_addr_i  <= REG_INFO_CONTROL_ONE;
    cfg_wdata_i <= o;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(REG_FRAME_ADDRESS, addr);
    sb.set_reg(REG_INFO_CONTROL_ZERO, z);
    sb.set_reg(REG_INFO_CONTROL_ONE, o);
  endtask

  // stop offering, wait for every expected transfer, then let the pipe empty
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] addr, z, o, input bit write_cfg,
                           input bit src_gaps, snk_gaps, stall_sink, input int budget);
    logic [7:0] line_q[$];
    int         sent;
    if (write_cfg) configure(addr, z, o);
    src_busy = src_gaps;
    snk_busy = snk_gaps;
    if (stall_sink) long_hold = 1'b1;
    sent = 0;
    while (sent < budget) begin
      line_q.delete();
      sent += build_burst(line_q, addr, z, o);
      foreach (line_q[i]) send_byte(line_q[i]);
    end
    drain();
  endtask

  localparam logic [7:0] DIRECTED [29] = '{
    8'hFF, FLAG_BYTE, FLAG_BYTE, FRAME_ADDRESS_RST, FLAG_BYTE,
    FRAME_ADDRESS_RST, INFO_CONTROL_ZERO_RST, FLAG_BYTE,
    FRAME_ADDRESS_RST, INFO_CONTROL_ONE_RST, FRAME_ADDRESS_RST ^ INFO_CONTROL_ONE_RST,
    FLAG_BYTE,
    FRAME_ADDRESS_RST, INFO_CONTROL_ZERO_RST, FRAME_ADDRESS_RST ^ INFO_CONTROL_ZERO_RST,
    8'h00, FLAG_BYTE,
    FLAG_BYTE, FRAME_ADDRESS_RST, INFO_CONTROL_ONE_RST,
    FRAME_ADDRESS_RST ^ INFO_CONTROL_ONE_RST,
    ESCAPE_BYTE, CODE_FLAG, ESCAPE_BYTE, CODE_ESC, ESCAPE_BYTE, 8'h11, ESCAPE_BYTE,
    FLAG_BYTE
  };

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // hunting corner cases, single byte frame, escape codes at reset settings
    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    run_phase(FRAME_ADDRESS_RST, INFO_CONTROL_ZERO_RST, INFO_CONTROL_ONE_RST,
              1'b0, 1'b1, 1'b1, 1'b0, 180);
    run_phase(8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 200);
    run_phase(8'hFF, 8'hFF, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 200);
    // address equals the flag and the sequence 0 header check does too
    run_phase(FLAG_BYTE, 8'h00, ESCAPE_BYTE, 1'b1, 1'b1, 1'b0, 1'b0, 200);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0, 1'b1, 1'b0, 200);
    run_phase(FRAME_ADDRESS_RST, INFO_CONTROL_ZERO_RST, INFO_CONTROL_ONE_RST,
              1'b1, 1'b1, 1'b1, 1'b0, 200);

    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        stall = pick_gap(snk_busy);
        if (stall > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_deframed(m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[8],
                        m_axis_tlast_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
